FILE: sv/edge_nms_with_border_taper_core_defines.svh
// assertion macros shared by the rtl
`ifndef EDGE_NMS_WITH_BORDER_TAPER_CORE_DEFINES_SVH
`define EDGE_NMS_WITH_BORDER_TAPER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// condition and consequence in the same cycle
`define ENMS_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequence in the following cycle
`define ENMS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ENMS_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define ENMS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: sv/enms_pkg.sv
package enms_pkg;

    localparam int STRENGTH_BITS = 16;
    localparam int ANGLE_BITS    = 10;
    localparam int QTR           = 1 << (ANGLE_BITS - 1);
    localparam int SIN_W         = 15;
    localparam int BORD_W        = 9;
    localparam int MULT_W        = 16;
    localparam int SIZE_CFG_W    = 10;
    localparam int RAD_CFG_W     = 4;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int DIV_NW        = 34;
    localparam int DIV_DW        = 18;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NMS_RADIUS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BORDER_WIDTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STRENGTH_MUL = 3'd4;

    localparam int RST_IMAGE_WIDTH  = 512;
    localparam int RST_IMAGE_HEIGHT = 512;
    localparam int RST_NMS_RADIUS   = 1;
    localparam int RST_BORDER_WIDTH = 5;
    localparam int RST_STRENGTH_MUL = 4137;

    typedef logic [SIN_W-1:0] t_sin_tab [0:QTR];

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLR_POS,
        OP_CENTER,
        OP_CDATA,
        OP_XY,
        OP_SIN,
        OP_COS,
        OP_CSET,
        OP_POS,
        OP_PREP,
        OP_ADDR,
        OP_RD,
        OP_MUL,
        OP_ACC,
        OP_NEXT_D,
        OP_TAP0,
        OP_TAP1,
        OP_TAP2,
        OP_DIV_TAP,
        OP_EMIT_ZERO,
        OP_EMIT_E,
        OP_EMIT_Q
    } t_op;

    typedef struct packed {
        logic accept;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic req;
        logic full;
        logic rd_over;
        logic e_zero;
        logic r_zero;
        logic k_last;
        logic d_last;
        logic supp;
        logic s_zero;
        logic div_done;
    } t_stat;

    // quarter-wave sine, Q1.14, polynomial in Q.24
    function automatic logic [SIN_W-1:0] f_quarter_sine(int unsigned k);
        longint unsigned u;
        longint unsigned u2;
        longint unsigned t;
        longint unsigned s;
        u  = longint'(k) << (17 - ANGLE_BITS);
        u2 = (u * u) >> 16;
        t  = 78548;
        t  = 1337020 - ((u2 * t) >> 16);
        t  = 10837479 - ((u2 * t) >> 16);
        t  = 26353589 - ((u2 * t) >> 16);
        s  = (((u * t) >> 16) + 512) >> 10;
        if (s > 16384) s = 16384;
        return SIN_W'(s);
    endfunction

    function automatic t_sin_tab f_sin_tab();
        t_sin_tab tab;
        for (int i = 0; i <= QTR; i++) begin
            tab[i] = f_quarter_sine(i);
        end
        return tab;
    endfunction

endpackage

FILE: sv/enms_div.sv
module enms_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [enms_pkg::DIV_NW-1:0] i_num,
    input  logic [enms_pkg::DIV_DW-1:0] i_den,
    output logic                        o_busy,
    output logic [enms_pkg::DIV_NW-1:0] o_quot,
    output logic [enms_pkg::DIV_DW-1:0] o_rem
);
    import enms_pkg::*;

    localparam int CNT_W = $clog2(DIV_NW + 1);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIV_NW-1:0] r_quot;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_DW:0]   trial;
    logic              ge;

    // restoring division, one quotient bit per cycle
    always_comb begin
        trial = {r_rem, r_quot[DIV_NW-1]};
        ge    = trial >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DIV_NW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_quot <= {r_quot[DIV_NW-2:0], ge};
            r_rem  <= ge ? DIV_DW'(trial - {1'b0, r_den}) : trial[DIV_DW-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

FILE: sv/enms_ctrl.sv
module enms_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    input  enms_pkg::t_stat i_stat,
    output enms_pkg::t_cmd  o_cmd
);
    import enms_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISP,
        S_CDATA,
        S_XYWAIT,
        S_CHK,
        S_SIN,
        S_COS,
        S_POS,
        S_PREP,
        S_ADDR,
        S_RD,
        S_MUL,
        S_ACC,
        S_CMP,
        S_TAP0,
        S_TAP1,
        S_TAP2,
        S_DIVGO,
        S_DIVWAIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    t_op    op;
    logic   accept;

    always_comb begin
        n_state = r_state;
        op      = OP_NONE;
        accept  = 1'b0;
        case (r_state)
            S_IDLE: begin
                accept = i_start;
                if (i_start) n_state = S_DISP;
            end
            S_DISP: begin
                if (!i_stat.req) begin
                    op      = OP_LOAD;
                    n_state = S_IDLE;
                end else if (!i_stat.full) begin
                    n_state = S_IDLE;
                end else if (i_stat.rd_over) begin
                    op      = OP_CLR_POS;
                    n_state = S_IDLE;
                end else begin
                    op      = OP_CENTER;
                    n_state = S_CDATA;
                end
            end
            S_CDATA: begin
                op      = OP_CDATA;
                n_state = S_XYWAIT;
            end
            S_XYWAIT: begin
                if (i_stat.div_done) begin
                    op      = OP_XY;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (i_stat.e_zero) begin
                    op      = OP_EMIT_ZERO;
                    n_state = S_IDLE;
                end else begin
                    op      = OP_SIN;
                    n_state = S_SIN;
                end
            end
            S_SIN: begin
                op      = OP_COS;
                n_state = S_COS;
            end
            S_COS: begin
                op      = OP_CSET;
                n_state = i_stat.r_zero ? S_TAP0 : S_POS;
            end
            S_POS: begin
                op      = OP_POS;
                n_state = S_PREP;
            end
            S_PREP: begin
                op      = OP_PREP;
                n_state = S_ADDR;
            end
            S_ADDR: begin
                op      = OP_ADDR;
                n_state = S_RD;
            end
            S_RD: begin
                op      = OP_RD;
                n_state = S_MUL;
            end
            S_MUL: begin
                op      = OP_MUL;
                n_state = S_ACC;
            end
            S_ACC: begin
                op      = OP_ACC;
                n_state = i_stat.k_last ? S_CMP : S_ADDR;
            end
            S_CMP: begin
                if (i_stat.supp) begin
                    op      = OP_EMIT_ZERO;
                    n_state = S_IDLE;
                end else if (i_stat.d_last) begin
                    n_state = S_TAP0;
                end else begin
                    op      = OP_NEXT_D;
                    n_state = S_POS;
                end
            end
            S_TAP0: begin
                op      = OP_TAP0;
                n_state = S_TAP1;
            end
            S_TAP1: begin
                if (i_stat.s_zero) begin
                    op      = OP_EMIT_E;
                    n_state = S_IDLE;
                end else begin
                    op      = OP_TAP1;
                    n_state = S_TAP2;
                end
            end
            S_TAP2: begin
                op      = OP_TAP2;
                n_state = S_DIVGO;
            end
            S_DIVGO: begin
                op      = OP_DIV_TAP;
                n_state = S_DIVWAIT;
            end
            S_DIVWAIT: begin
                if (i_stat.div_done) begin
                    op      = OP_EMIT_Q;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_state != S_IDLE;
        end
    end

    assign o_busy       = r_busy;
    assign o_cmd.accept = accept;
    assign o_cmd.op     = op;

endmodule

FILE: sv/enms_dp.sv
module enms_dp #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int MAX_RADIUS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  enms_pkg::t_cmd                     i_cmd,
    output enms_pkg::t_stat                    o_stat,
    input  logic                               i_req_type,
    input  logic [enms_pkg::STRENGTH_BITS-1:0] i_edge_in,
    input  logic [enms_pkg::ANGLE_BITS-1:0]    i_angle_in,
    input  logic                               i_cfg_we,
    input  logic [enms_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [enms_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                               o_strobe,
    output logic [enms_pkg::STRENGTH_BITS-1:0] o_edge_out,
    output logic                               o_last_pixel
);
    import enms_pkg::*;

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int WSW   = $clog2(MAX_WIDTH + 1);
    localparam int HSW   = $clog2(MAX_HEIGHT + 1);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(DEPTH + 1);
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int DSW   = RW + 1;
    localparam int PRW   = RW + 17;
    localparam int MXW   = (XW > YW) ? XW : YW;
    localparam int CW    = ((MXW > RW) ? MXW : RW) + 12;
    localparam int SW0   = (WSW > HSW) ? WSW : HSW;
    localparam int SW    = (SW0 > BORD_W) ? SW0 : BORD_W;
    localparam int WORD  = STRENGTH_BITS + ANGLE_BITS;
    localparam int EMW   = 2 * STRENGTH_BITS + 4;
    localparam int ACW   = 2 * STRENGTH_BITS + 2;
    localparam int N1W   = STRENGTH_BITS + BORD_W;
    localparam int WGW   = 18;
    localparam int RST_W = (RST_IMAGE_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_IMAGE_WIDTH;
    localparam int RST_H = (RST_IMAGE_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_IMAGE_HEIGHT;
    localparam int RST_R = (RST_NMS_RADIUS > MAX_RADIUS) ? MAX_RADIUS : RST_NMS_RADIUS;

    localparam t_sin_tab SIN_TAB = f_sin_tab();

    // configuration
    logic [WSW-1:0]    r_w;
    logic [HSW-1:0]    r_h;
    logic [RW-1:0]     r_rad;
    logic [BORD_W-1:0] r_bord;
    logic [MULT_W-1:0] r_mult;
    logic [SIZE_CFG_W-1:0] v_w;
    logic [SIZE_CFG_W-1:0] v_h;
    logic [RAD_CFG_W-1:0]  v_r;
    logic [WSW-1:0]    w_clamp;
    logic [HSW-1:0]    h_clamp;
    logic [RW-1:0]     r_clamp;

    // frame positions and input capture
    logic [PW-1:0]            r_lpos;
    logic [PW-1:0]            r_rpos;
    logic [PW-1:0]            total;
    logic                     full;
    logic                     rd_over;
    logic                     last;
    logic                     r_req;
    logic [STRENGTH_BITS-1:0] r_ein;
    logic [ANGLE_BITS-1:0]    r_ain;

    // pixel store
    logic [WORD-1:0] r_mem [0:DEPTH-1];
    logic [WORD-1:0] r_mem_q;

    // pixel and orientation
    logic [STRENGTH_BITS-1:0] r_e;
    logic [ANGLE_BITS-1:0]    r_a;
    logic [XW-1:0]            r_x;
    logic [YW-1:0]            r_y;
    logic [SIN_W-1:0]         r_rom_q;
    logic [ANGLE_BITS-1:0]    rom_idx;
    logic [ANGLE_BITS:0]      wrap_idx;
    logic                     a_upper;
    logic signed [15:0]       r_c;
    logic signed [15:0]       r_sn;
    logic [EMW-1:0]           r_em;
    logic signed [DSW-1:0]    r_d;

    // sample positions
    logic signed [PRW-1:0] prod_x;
    logic signed [PRW-1:0] prod_y;
    logic signed [PRW-1:0] off_x;
    logic signed [PRW-1:0] off_y;
    logic signed [CW-1:0]  px_raw;
    logic signed [CW-1:0]  py_raw;
    logic signed [CW-1:0]  lim_x;
    logic signed [CW-1:0]  lim_y;
    logic signed [CW-1:0]  px_cl;
    logic signed [CW-1:0]  py_cl;
    logic [XW+7:0]         r_px;
    logic [YW+7:0]         r_py;

    // bilinear corners
    logic [XW-1:0]  r_x0;
    logic [XW-1:0]  r_x1;
    logic [YW-1:0]  r_y0;
    logic [YW-1:0]  r_y1;
    logic [7:0]     r_fx;
    logic [7:0]     r_fy;
    logic [1:0]     r_k;
    logic [XW-1:0]  xi;
    logic [YW-1:0]  yi;
    logic [8:0]     wx;
    logic [8:0]     wy;
    logic [AW-1:0]  r_addr;
    logic [WGW-1:0] r_wgt;
    logic [ACW-1:0] r_prod;
    logic [ACW-1:0] r_acc;

    // taper
    logic [SW-1:0]     s_full;
    logic [SW-1:0]     xs;
    logic [SW-1:0]     ys;
    logic [SW-1:0]     nx_full;
    logic [SW-1:0]     ny_full;
    logic [BORD_W-1:0] r_s;
    logic [BORD_W-1:0] r_nx;
    logic [BORD_W-1:0] r_ny;
    logic [N1W-1:0]    r_num1;
    logic [DIV_NW-1:0] r_num;
    logic [DIV_DW-1:0] r_den;

    // divider
    logic              div_start;
    logic [DIV_NW-1:0] div_num;
    logic [DIV_DW-1:0] div_den;
    logic              div_busy;
    logic [DIV_NW-1:0] div_quot;
    logic [DIV_DW-1:0] div_rem;

    // output
    logic                     r_strobe;
    logic                     r_last;
    logic [STRENGTH_BITS-1:0] r_out;

    // config clamping
    always_comb begin
        v_w = i_cfg_data[SIZE_CFG_W-1:0];
        v_h = i_cfg_data[SIZE_CFG_W-1:0];
        v_r = i_cfg_data[RAD_CFG_W-1:0];
        if (v_w == '0) w_clamp = WSW'(1);
        else if (32'(v_w) > MAX_WIDTH) w_clamp = WSW'(MAX_WIDTH);
        else w_clamp = WSW'(v_w);
        if (v_h == '0) h_clamp = HSW'(1);
        else if (32'(v_h) > MAX_HEIGHT) h_clamp = HSW'(MAX_HEIGHT);
        else h_clamp = HSW'(v_h);
        if (32'(v_r) > MAX_RADIUS) r_clamp = RW'(MAX_RADIUS);
        else r_clamp = RW'(v_r);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w    <= WSW'(RST_W);
            r_h    <= HSW'(RST_H);
            r_rad  <= RW'(RST_R);
            r_bord <= BORD_W'(RST_BORDER_WIDTH);
            r_mult <= MULT_W'(RST_STRENGTH_MUL);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IMAGE_WIDTH:  r_w    <= w_clamp;
                CFG_IMAGE_HEIGHT: r_h    <= h_clamp;
                CFG_NMS_RADIUS:   r_rad  <= r_clamp;
                CFG_BORDER_WIDTH: r_bord <= i_cfg_data[BORD_W-1:0];
                CFG_STRENGTH_MUL: r_mult <= i_cfg_data[MULT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        total   = PW'(r_w) * PW'(r_h);
        full    = r_lpos >= total;
        rd_over = r_rpos >= total;
        last    = PW'(r_rpos + PW'(1)) == total;
    end

    // positions, transfer capture and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lpos   <= '0;
            r_rpos   <= '0;
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
            case (i_cmd.op)
                OP_LOAD: begin
                    if (!full) r_lpos <= r_lpos + PW'(1);
                end
                OP_CLR_POS: begin
                    r_lpos <= '0;
                    r_rpos <= '0;
                end
                OP_EMIT_ZERO, OP_EMIT_E, OP_EMIT_Q: begin
                    r_strobe <= 1'b1;
                    r_last   <= last;
                    if (last) begin
                        r_lpos <= '0;
                        r_rpos <= '0;
                    end else begin
                        r_rpos <= r_rpos + PW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req <= i_req_type;
            r_ein <= i_edge_in;
            r_ain <= i_angle_in;
        end
        case (i_cmd.op)
            OP_EMIT_ZERO: r_out <= '0;
            OP_EMIT_E:    r_out <= r_e;
            OP_EMIT_Q:    r_out <= div_quot[STRENGTH_BITS-1:0];
            default: begin
            end
        endcase
    end

    // single-port pixel store with registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD && !full) r_mem[r_lpos[AW-1:0]] <= {r_ein, r_ain};
        if (i_cmd.op == OP_CENTER) r_mem_q <= r_mem[r_rpos[AW-1:0]];
        else if (i_cmd.op == OP_RD) r_mem_q <= r_mem[r_addr];
    end

    // divider shares pos / height and the taper quotient
    always_comb begin
        div_start = (i_cmd.op == OP_CENTER) || (i_cmd.op == OP_DIV_TAP);
        if (i_cmd.op == OP_CENTER) begin
            div_num = DIV_NW'(r_rpos);
            div_den = DIV_DW'(r_h);
        end else begin
            div_num = r_num;
            div_den = r_den;
        end
    end

    enms_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quot  (div_quot),
        .o_rem   (div_rem)
    );

    // angle table index: sin on the first lookup, cos on the second
    always_comb begin
        a_upper  = 32'(r_a) > QTR;
        wrap_idx = '0;
        if (i_cmd.op == OP_SIN) begin
            wrap_idx = a_upper ? (ANGLE_BITS+1)'((1 << ANGLE_BITS) - 32'(r_a))
                               : (ANGLE_BITS+1)'(r_a);
        end else begin
            wrap_idx = a_upper ? (ANGLE_BITS+1)'(32'(r_a) - QTR)
                               : (ANGLE_BITS+1)'(QTR - 32'(r_a));
        end
        rom_idx = wrap_idx[ANGLE_BITS-1:0];
    end

    // sample position, rounded half up and clamped inside the frame
    always_comb begin
        prod_x = PRW'(r_d) * PRW'(r_c);
        prod_y = PRW'(r_d) * PRW'(r_sn);
        off_x  = (prod_x + PRW'(32)) >>> 6;
        off_y  = (prod_y + PRW'(32)) >>> 6;
        px_raw = CW'($signed({1'b0, r_x, 8'd0})) + CW'(off_x);
        py_raw = CW'($signed({1'b0, r_y, 8'd0})) + CW'(off_y);
        lim_x  = (r_w == WSW'(1)) ? '0 : CW'({1'b0, WSW'(r_w - WSW'(2)), 8'hFF});
        lim_y  = (r_h == HSW'(1)) ? '0 : CW'({1'b0, HSW'(r_h - HSW'(2)), 8'hFF});
        if (px_raw[CW-1]) px_cl = '0;
        else if (px_raw > lim_x) px_cl = lim_x;
        else px_cl = px_raw;
        if (py_raw[CW-1]) py_cl = '0;
        else if (py_raw > lim_y) py_cl = lim_y;
        else py_cl = py_raw;
    end

    // corner select and weights
    always_comb begin
        xi = r_k[0] ? r_x1 : r_x0;
        yi = r_k[1] ? r_y1 : r_y0;
        wx = r_k[0] ? {1'b0, r_fx} : 9'(9'd256 - {1'b0, r_fx});
        wy = r_k[1] ? {1'b0, r_fy} : 9'(9'd256 - {1'b0, r_fy});
    end

    // taper band
    always_comb begin
        s_full = SW'(r_bord);
        if (SW'(r_w >> 1) < s_full) s_full = SW'(r_w >> 1);
        if (SW'(r_h >> 1) < s_full) s_full = SW'(r_h >> 1);
        xs = SW'(r_x);
        ys = SW'(r_y);
        if (xs < s_full) nx_full = xs;
        else if (xs >= SW'(SW'(r_w) - s_full)) nx_full = SW'(SW'(r_w) - SW'(1) - xs);
        else nx_full = s_full;
        if (ys < s_full) ny_full = ys;
        else if (ys >= SW'(SW'(r_h) - s_full)) ny_full = SW'(SW'(r_h) - SW'(1) - ys);
        else ny_full = s_full;
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CDATA: begin
                r_e <= r_mem_q[WORD-1:ANGLE_BITS];
                r_a <= r_mem_q[ANGLE_BITS-1:0];
            end
            OP_XY: begin
                r_x <= div_quot[XW-1:0];
                r_y <= div_rem[YW-1:0];
            end
            OP_SIN: begin
                r_rom_q <= SIN_TAB[rom_idx];
                r_em    <= {32'(r_e) * 32'(r_mult), 4'b0};
            end
            OP_COS: begin
                r_rom_q <= SIN_TAB[rom_idx];
                r_sn    <= $signed({1'b0, r_rom_q});
            end
            OP_CSET: begin
                r_c <= a_upper ? -$signed({1'b0, r_rom_q}) : $signed({1'b0, r_rom_q});
                r_d <= -$signed({1'b0, r_rad});
            end
            OP_POS: begin
                r_px <= px_cl[XW+7:0];
                r_py <= py_cl[YW+7:0];
            end
            OP_PREP: begin
                r_x0 <= r_px[XW+7:8];
                r_y0 <= r_py[YW+7:8];
                r_fx <= r_px[7:0];
                r_fy <= r_py[7:0];
                r_x1 <= ((XW+1)'(r_px[XW+7:8]) + (XW+1)'(1) < (XW+1)'(r_w))
                        ? XW'(r_px[XW+7:8] + XW'(1)) : XW'(r_w - WSW'(1));
                r_y1 <= ((YW+1)'(r_py[YW+7:8]) + (YW+1)'(1) < (YW+1)'(r_h))
                        ? YW'(r_py[YW+7:8] + YW'(1)) : YW'(r_h - HSW'(1));
                r_k   <= '0;
                r_acc <= '0;
            end
            OP_ADDR: begin
                r_addr <= AW'(AW'(xi) * AW'(r_h) + AW'(yi));
                r_wgt  <= WGW'(wx) * WGW'(wy);
            end
            OP_MUL: begin
                r_prod <= ACW'(r_mem_q[WORD-1:ANGLE_BITS]) * ACW'(r_wgt);
            end
            OP_ACC: begin
                r_acc <= r_acc + r_prod;
                r_k   <= r_k + 2'd1;
            end
            OP_NEXT_D: begin
                if (r_d == '1) r_d <= DSW'(1);
                else r_d <= r_d + DSW'(1);
            end
            OP_TAP0: begin
                r_s  <= s_full[BORD_W-1:0];
                r_nx <= nx_full[BORD_W-1:0];
                r_ny <= ny_full[BORD_W-1:0];
            end
            OP_TAP1: begin
                r_num1 <= N1W'(r_e) * N1W'(r_nx);
                r_den  <= DIV_DW'(r_s) * DIV_DW'(r_s);
            end
            OP_TAP2: begin
                r_num <= DIV_NW'(r_num1) * DIV_NW'(r_ny);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_stat.req      = r_req;
        o_stat.full     = full;
        o_stat.rd_over  = rd_over;
        o_stat.e_zero   = r_e == '0;
        o_stat.r_zero   = r_rad == '0;
        o_stat.k_last   = r_k == 2'd3;
        o_stat.d_last   = r_d == $signed({1'b0, r_rad});
        o_stat.supp     = r_em < EMW'(r_acc);
        o_stat.s_zero   = r_s == '0;
        o_stat.div_done = !div_busy;
    end

    assign o_strobe     = r_strobe;
    assign o_edge_out   = r_out;
    assign o_last_pixel = r_last;

endmodule

FILE: sv/edge_nms_with_border_taper_core.sv
// channel   direction  ports                                     transfer
// item      in         start, busy, i_req_type, i_edge_in,       start high, busy low
//                      i_angle_in
// result    out        o_strobe, o_edge_out, o_last_pixel        o_strobe high, one cycle
// config    in         i_cfg_we, i_cfg_idx, i_cfg_data           i_cfg_we high
//
// a load, or a read request that is not served, returns to idle from the dispatch state
// a served read runs the serial divider for the pixel index to column/row and, unless
// the taper band is zero, for the taper quotient; each bilinear sample makes four
// reads of the single-port pixel store
// zero strength returns without sampling, a suppressed pixel at its first failing sample
// reset is synchronous and clears control and configuration; the pixel store is not cleared
// results cannot be stalled; the next item may start in the cycle a result is shown
`include "edge_nms_with_border_taper_core_defines.svh"

module edge_nms_with_border_taper_core #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int MAX_RADIUS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_req_type,
    input  logic [enms_pkg::STRENGTH_BITS-1:0] i_edge_in,
    input  logic [enms_pkg::ANGLE_BITS-1:0]    i_angle_in,
    input  logic                               i_cfg_we,
    input  logic [enms_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [enms_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                               o_strobe,
    output logic [enms_pkg::STRENGTH_BITS-1:0] o_edge_out,
    output logic                               o_last_pixel
);
    import enms_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    enms_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    enms_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_req_type   (i_req_type),
        .i_edge_in    (i_edge_in),
        .i_angle_in   (i_angle_in),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_strobe     (o_strobe),
        .o_edge_out   (o_edge_out),
        .o_last_pixel (o_last_pixel)
    );

    `ENMS_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `ENMS_ASSERT_NEXT(a_single_result, i_clk, i_rst_n, o_strobe, !o_strobe)
    `ENMS_ASSERT_SAME(a_last_with_strobe, i_clk, i_rst_n, o_last_pixel, o_strobe)

endmodule
